/* rtl/core/text_terminal_buffer_defines.svh */
// Assertion macros for the text terminal buffer.
`ifndef TEXT_TERMINAL_BUFFER_DEFINES_SVH
`define TEXT_TERMINAL_BUFFER_DEFINES_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define TTB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ttb assertion failed");
// Checked at every edge, reset included.
`define TTB_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ttb assertion failed");
`else
`define TTB_ASSERT(label, prop)
`define TTB_ASSERT_ALWAYS(label, prop)
`endif
`endif

/* rtl/core/ttb_pkg.sv */
// Package: screen geometry, command codes and shared types of the text terminal buffer.
`timescale 1ns / 1ps
package ttb_pkg;

  localparam int COLUMNS = 32;
  localparam int ROWS    = 8;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COORD_W = 10;
  localparam int CHAR_W  = 8;
  localparam logic [CHAR_W-1:0] BLANK = CHAR_W'(32);

  typedef enum logic [2:0] {
    CMD_PUT   = 3'd0,
    CMD_NL    = 3'd1,
    CMD_MOVE  = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_READ  = 3'd4,
    CMD_DIRTY = 3'd5
  } cmd_t;

  typedef enum logic {
    ST_RUN,
    ST_READ
  } state_t;

  // Control from the command logic to the cell store
  typedef struct packed {
    logic              wr_en;
    logic [ROW_W-1:0]  wr_row;
    logic [COL_W-1:0]  wr_col;
    logic [CHAR_W-1:0] wr_data;
    logic              rd_en;
    logic [ROW_W-1:0]  rd_row;
    logic [COL_W-1:0]  rd_col;
    logic              blank_en;
    logic [ROW_W-1:0]  blank_row;
    logic              clear_all;
  } store_ctl_t;

  function automatic logic [COL_W-1:0] clamp_col(input logic signed [COORD_W-1:0] v);
    if (v < 0) return '0;
    else if (v >= COLUMNS) return COL_W'(COLUMNS - 1);
    else return v[COL_W-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] clamp_row(input logic signed [COORD_W-1:0] v);
    if (v < 0) return '0;
    else if (v >= ROWS) return ROW_W'(ROWS - 1);
    else return v[ROW_W-1:0];
  endfunction

  // Screen row to store row, given the row currently at the top
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = {1'b0, lrow} + {1'b0, top};
    if (sum >= (ROW_W+1)'(ROWS)) sum = sum - (ROW_W+1)'(ROWS);
    return sum[ROW_W-1:0];
  endfunction

endpackage

/* rtl/core/ttb_cell_store.sv */
// Character memory with one valid bit per cell; an invalid cell reads as a space.
`timescale 1ns / 1ps
module ttb_cell_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ttb_pkg::store_ctl_t       ctl,
  output logic [ttb_pkg::CHAR_W-1:0] rd_char
);
  import ttb_pkg::*;

  logic [CHAR_W-1:0]  mem [CELLS];
  logic [COLUMNS-1:0] vld_r [ROWS];
  logic [COLUMNS-1:0] vld_nxt [ROWS];
  logic [CHAR_W-1:0]  rd_data_r;
  logic               rd_vld_r;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;

  assign wr_addr = ADDR_W'(ctl.wr_row) * ADDR_W'(COLUMNS) + ADDR_W'(ctl.wr_col);
  assign rd_addr = ADDR_W'(ctl.rd_row) * ADDR_W'(COLUMNS) + ADDR_W'(ctl.rd_col);

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      vld_nxt[r] = vld_r[r];
      if (ctl.clear_all || (ctl.blank_en && ctl.blank_row == ROW_W'(r))) begin
        vld_nxt[r] = '0;
      end
      if (ctl.wr_en && ctl.wr_row == ROW_W'(r)) begin
        vld_nxt[r][ctl.wr_col] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        vld_r[r] <= '0;
      end
      rd_vld_r <= 1'b0;
    end else begin
      for (int r = 0; r < ROWS; r++) begin
        vld_r[r] <= vld_nxt[r];
      end
      if (ctl.rd_en) begin
        rd_vld_r <= vld_r[ctl.rd_row][ctl.rd_col];
      end
    end
  end

  assign rd_char = rd_vld_r ? rd_data_r : BLANK;

endmodule

/* rtl/core/text_terminal_buffer.sv */
// Top level: command decode, cursor, row dirty flags, scroll offset and result register.
//
//  channel  dir  handshake              payload
//  in_      in   in_valid / in_stall    cmd, char_code, col, row
//  out_     out  out_valid / out_stall  cursor_col, cursor_row, cell_char, row_dirty, scrolled
//
// One item a cycle unless the input is stalled; read cell also passes through a read
// state, as the cell store has a registered read port. Scrolling rotates a top-row
// offset and blanks a row through per-cell valid bits, so it adds no wait state.
// Reset (synchronous, rst_n low) clears the valid bits, so the screen reads as spaces.
// A held result stalls the input until it is taken.
`timescale 1ns / 1ps
`include "text_terminal_buffer_defines.svh"
module text_terminal_buffer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         in_cmd,
  input  logic [ttb_pkg::CHAR_W-1:0]         in_char_code,
  input  logic signed [ttb_pkg::COORD_W-1:0] in_col,
  input  logic signed [ttb_pkg::COORD_W-1:0] in_row,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [4:0]                         out_cursor_col,
  output logic [2:0]                         out_cursor_row,
  output logic [ttb_pkg::CHAR_W-1:0]         out_cell_char,
  output logic                               out_row_dirty,
  output logic                               out_scrolled
);
  import ttb_pkg::*;

  state_t            state_r, state_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [ROW_W-1:0]  top_r, top_nxt;
  logic [ROWS-1:0]   dirty_r, dirty_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [4:0]        out_col_r, out_col_nxt;
  logic [2:0]        out_row_r, out_row_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_dirty_r, out_dirty_nxt;
  logic              out_scr_r, out_scr_nxt;

  store_ctl_t        ctl;
  logic [CHAR_W-1:0] rd_char;
  logic              acc;
  logic [COL_W-1:0]  cl_col;
  logic [ROW_W-1:0]  cl_row;
  logic              scroll;

  assign in_stall = (state_r == ST_READ) || (out_valid_r && out_stall);
  assign acc      = in_valid && !in_stall;
  assign cl_col   = clamp_col(in_col);
  assign cl_row   = clamp_row(in_row);

  always_comb begin
    state_nxt     = state_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    top_nxt       = top_r;
    dirty_nxt     = dirty_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_char_nxt  = out_char_r;
    out_dirty_nxt = out_dirty_r;
    out_scr_nxt   = out_scr_r;
    scroll        = 1'b0;
    ctl           = '0;

    case (state_r)
      ST_RUN: begin
        if (acc) begin
          out_char_nxt  = '0;
          out_dirty_nxt = 1'b0;
          case (in_cmd)
            CMD_PUT: begin
              ctl.wr_en   = 1'b1;
              ctl.wr_row  = phys_row(cur_row_r, top_r);
              ctl.wr_col  = cur_col_r;
              ctl.wr_data = in_char_code;
              dirty_nxt[cur_row_r] = 1'b1;
              if (cur_col_r == COL_W'(COLUMNS - 1)) begin
                cur_col_nxt = '0;
                if (cur_row_r == ROW_W'(ROWS - 1)) begin
                  scroll = 1'b1;
                end else begin
                  cur_row_nxt = cur_row_r + 1'b1;
                end
              end else begin
                cur_col_nxt = cur_col_r + 1'b1;
              end
            end
            CMD_NL: begin
              cur_col_nxt = '0;
              if (cur_row_r == ROW_W'(ROWS - 1)) begin
                scroll = 1'b1;
              end else begin
                cur_row_nxt = cur_row_r + 1'b1;
              end
              ctl.blank_en  = 1'b1;
              ctl.blank_row = phys_row(cur_row_nxt, top_r);
              dirty_nxt[cur_row_nxt] = 1'b1;
            end
            CMD_MOVE: begin
              cur_col_nxt = cl_col;
              cur_row_nxt = cl_row;
            end
            CMD_CLEAR: begin
              ctl.clear_all = 1'b1;
              dirty_nxt     = '1;
              cur_col_nxt   = '0;
              cur_row_nxt   = '0;
              top_nxt       = '0;
            end
            CMD_READ: begin
              ctl.rd_en  = 1'b1;
              ctl.rd_row = phys_row(cl_row, top_r);
              ctl.rd_col = cl_col;
              state_nxt  = ST_READ;
            end
            CMD_DIRTY: begin
              out_dirty_nxt     = dirty_r[cl_row];
              dirty_nxt[cl_row] = 1'b0;
            end
            default: begin
            end
          endcase
          // Scroll: old top row becomes the blank bottom row
          if (scroll) begin
            ctl.blank_en  = 1'b1;
            ctl.blank_row = top_r;
            top_nxt       = phys_row(ROW_W'(1), top_r);
            dirty_nxt     = '1;
          end
          out_scr_nxt = scroll;
          out_col_nxt = 5'(cur_col_nxt);
          out_row_nxt = 3'(cur_row_nxt);
          if (in_cmd != CMD_READ) begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_READ: begin
        out_char_nxt  = rd_char;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_RUN;
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      top_r       <= '0;
      dirty_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      top_r       <= top_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_char_r  <= out_char_nxt;
    out_dirty_r <= out_dirty_nxt;
    out_scr_r   <= out_scr_nxt;
  end

  ttb_cell_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_char (rd_char)
  );

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_cell_char  = out_char_r;
  assign out_row_dirty  = out_dirty_r;
  assign out_scrolled   = out_scr_r;

  `TTB_ASSERT(a_read_enters_wait, (acc && in_cmd == CMD_READ) |=> (state_r == ST_READ))
  `TTB_ASSERT(a_read_gives_item, (state_r == ST_READ) |=> out_valid)
  `TTB_ASSERT(a_scroll_at_bottom, (out_valid && out_scrolled) |-> (out_cursor_row == 3'(ROWS - 1) && out_cursor_col == '0))
  `TTB_ASSERT(a_one_source, (state_r == ST_READ) |-> !(out_valid && out_stall))
  `TTB_ASSERT_ALWAYS(a_reset_empty, !$past(rst_n) |-> !out_valid)

endmodule

/* bench/text_terminal_buffer_checker.sv */
// Checker for the text terminal buffer: tracks the screen, predicts each result and compares.
`timescale 1ns / 1ps
module text_terminal_buffer_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [2:0]                           in_cmd,
  input  logic [ttb_pkg::CHAR_W-1:0]           in_char_code,
  input  logic signed [ttb_pkg::COORD_W-1:0]   in_col,
  input  logic signed [ttb_pkg::COORD_W-1:0]   in_row,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [4:0]                           out_cursor_col,
  input  logic [2:0]                           out_cursor_row,
  input  logic [ttb_pkg::CHAR_W-1:0]           out_cell_char,
  input  logic                                 out_row_dirty,
  input  logic                                 out_scrolled,
  output int                                   fail_count,
  output int                                   pending
);
  import ttb_pkg::*;

  typedef struct packed {
    logic [4:0]        ccol;
    logic [2:0]        crow;
    logic [CHAR_W-1:0] chr;
    logic              dirty;
    logic              scr;
  } term_result_t;

  logic [CHAR_W-1:0] screen [ROWS][COLUMNS];
  logic [ROWS-1:0]   dirty_flags;
  int                cur_col;
  int                cur_row;
  term_result_t      awaited_results[$];

  function automatic int limit_coord(input logic signed [COORD_W-1:0] v, input int span);
    if (v < 0) return 0;
    if (v >= span) return span - 1;
    return int'(v);
  endfunction

  task automatic blank_screen();
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLUMNS; c++)
        screen[r][c] = BLANK;
  endtask

  task automatic scroll_screen();
    for (int r = 0; r < ROWS - 1; r++)
      screen[r] = screen[r+1];
    for (int c = 0; c < COLUMNS; c++)
      screen[ROWS-1][c] = BLANK;
    dirty_flags = '1;
  endtask

  task automatic apply_command(input logic [2:0] cmd, input logic [CHAR_W-1:0] ch,
                               input logic signed [COORD_W-1:0] cc,
                               input logic signed [COORD_W-1:0] rr,
                               output term_result_t res);
    int pos;
    int c;
    int r;
    res = '0;
    case (cmd)
      CMD_PUT: begin
        pos = cur_row * COLUMNS + cur_col;
        dirty_flags[cur_row] = 1'b1;
        screen[cur_row][cur_col] = ch;
        pos++;
        if (pos >= CELLS) begin
          scroll_screen();
          res.scr = 1'b1;
          pos -= COLUMNS;
        end
        cur_col = pos % COLUMNS;
        cur_row = pos / COLUMNS;
      end
      CMD_NL: begin
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS) begin
          scroll_screen();
          res.scr = 1'b1;
          cur_row = ROWS - 1;
        end
        for (int i = 0; i < COLUMNS; i++)
          screen[cur_row][i] = BLANK;
        dirty_flags[cur_row] = 1'b1;
      end
      CMD_MOVE: begin
        cur_col = limit_coord(cc, COLUMNS);
        cur_row = limit_coord(rr, ROWS);
      end
      CMD_CLEAR: begin
        blank_screen();
        dirty_flags = '1;
        cur_col = 0;
        cur_row = 0;
      end
      CMD_READ: begin
        c = limit_coord(cc, COLUMNS);
        r = limit_coord(rr, ROWS);
        res.chr = screen[r][c];
      end
      CMD_DIRTY: begin
        r = limit_coord(rr, ROWS);
        res.dirty = dirty_flags[r];
        dirty_flags[r] = 1'b0;
      end
      default: ;  // unused codes leave everything alone
    endcase
    res.ccol = cur_col[4:0];
    res.crow = cur_row[2:0];
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial fail_count = 0;
  initial pending = 0;

  always @(posedge clk) begin
    term_result_t res;
    term_result_t want;
    if (!rst_n) begin
      blank_screen();
      dirty_flags = '0;
      cur_col = 0;
      cur_row = 0;
      awaited_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        apply_command(in_cmd, in_char_code, in_col, in_row, res);
        awaited_results.push_back(res);
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h/%0h", $time,
                   out_cursor_col, out_cursor_row);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("cursor_col", 8'(want.ccol), 8'(out_cursor_col));
          check_field("cursor_row", 8'(want.crow), 8'(out_cursor_row));
          check_field("cell_char", want.chr, out_cell_char);
          check_field("row_dirty", 8'(want.dirty), 8'(out_row_dirty));
          check_field("scrolled", 8'(want.scr), 8'(out_scrolled));
        end
      end
    end
    pending = awaited_results.size();
  end

endmodule

/* bench/text_terminal_buffer_tb.sv */
// Testbench top: clock, reset, command stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps
module text_terminal_buffer_tb;
  import ttb_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_CYCLES  = 300;
  localparam int CALM_ITEMS   = 150;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [2:0]                in_cmd = '0;
  logic [CHAR_W-1:0]         in_char_code = '0;
  logic signed [COORD_W-1:0] in_col = '0;
  logic signed [COORD_W-1:0] in_row = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [4:0]                out_cursor_col;
  logic [2:0]                out_cursor_row;
  logic [CHAR_W-1:0]         out_cell_char;
  logic                      out_row_dirty;
  logic                      out_scrolled;
  int                        fail_count;
  int                        pending;
  int                        sent = 0;
  bit                        calm = 1'b0;

  always #5 clk = ~clk;

  text_terminal_buffer DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_char_code  (in_char_code),
    .in_col        (in_col),
    .in_row        (in_row),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cursor_col(out_cursor_col),
    .out_cursor_row(out_cursor_row),
    .out_cell_char (out_cell_char),
    .out_row_dirty (out_row_dirty),
    .out_scrolled  (out_scrolled)
  );

  text_terminal_buffer_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_char_code  (in_char_code),
    .in_col        (in_col),
    .in_row        (in_row),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cursor_col(out_cursor_col),
    .out_cursor_row(out_cursor_row),
    .out_cell_char (out_cell_char),
    .out_row_dirty (out_row_dirty),
    .out_scrolled  (out_scrolled),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Offer one item, with an occasional idle burst first; returns once accepted.
  task automatic send_cmd(input logic [2:0] c, input logic [CHAR_W-1:0] ch,
                          input logic signed [COORD_W-1:0] cc,
                          input logic signed [COORD_W-1:0] rr);
    int gap;
    if (!calm && ((sent / 128) % 3 != 2) && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_cmd       <= c;
    in_char_code <= ch;
    in_col       <= cc;
    in_row       <= rr;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord(input int span);
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return COORD_W'($urandom_range(0, span - 1));
    if (r < 17) return COORD_W'(int'($urandom_range(0, span + 3)) - 2);
    return COORD_W'($urandom());
  endfunction

  task automatic random_cmd();
    int kind;
    int run;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      send_cmd(CMD_PUT, 8'($urandom()), pick_coord(COLUMNS), pick_coord(ROWS));
    end else if (kind < 45) begin
      // burst of text
      run = $urandom_range(2, 40);
      repeat (run)
        send_cmd(CMD_PUT, 8'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()));
    end else if (kind < 55) begin
      send_cmd(CMD_NL, 8'($urandom()), pick_coord(COLUMNS), pick_coord(ROWS));
    end else if (kind < 67) begin
      send_cmd(CMD_MOVE, 8'($urandom()), pick_coord(COLUMNS), pick_coord(ROWS));
    end else if (kind < 70) begin
      send_cmd(CMD_CLEAR, 8'($urandom()), pick_coord(COLUMNS), pick_coord(ROWS));
    end else if (kind < 84) begin
      send_cmd(CMD_READ, 8'($urandom()), pick_coord(COLUMNS), pick_coord(ROWS));
    end else if (kind < 96) begin
      send_cmd(CMD_DIRTY, 8'($urandom()), pick_coord(COLUMNS), pick_coord(ROWS));
    end else begin
      send_cmd(3'($urandom_range(6, 7)), 8'($urandom()), COORD_W'($urandom()),
               COORD_W'($urandom()));
    end
  endtask

  // Receiver: random stall bursts, one long hold-off once the run is under way
  initial begin
    int burst;
    int cyc;
    int hold_left;
    bit held;
    burst = 0;
    cyc = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (!held && sent >= 400) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (!calm && ((cyc / 200) % 3 != 1) && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 17) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("text_terminal_buffer test failed");
    $finish;
  end

  initial begin
    int goal;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every command, clamping, wrap and both scroll paths
    send_cmd(CMD_DIRTY, 8'h00, 10'sd0, 10'sd0);
    send_cmd(CMD_READ, 8'h00, -10'sd512, -10'sd512);
    send_cmd(CMD_PUT, 8'h00, 10'sd0, 10'sd0);
    send_cmd(CMD_PUT, 8'hFF, 10'sd511, 10'sd511);
    send_cmd(CMD_READ, 8'hFF, 10'sd0, 10'sd0);
    send_cmd(CMD_READ, 8'h00, 10'sd1, 10'sd0);
    send_cmd(CMD_MOVE, 8'h00, 10'sd511, 10'sd511);
    send_cmd(CMD_PUT, 8'hA5, 10'sd0, 10'sd0);
    send_cmd(CMD_READ, 8'h00, 10'sd511, 10'sd511);
    send_cmd(CMD_MOVE, 8'h00, 10'sd31, 10'sd3);
    send_cmd(CMD_PUT, 8'h5A, 10'sd0, 10'sd0);
    send_cmd(CMD_NL, 8'h00, 10'sd0, 10'sd0);
    send_cmd(CMD_MOVE, 8'h00, 10'sd5, 10'sd7);
    send_cmd(CMD_NL, 8'hFF, -10'sd1, -10'sd1);
    send_cmd(CMD_DIRTY, 8'h00, 10'sd0, -10'sd512);
    send_cmd(CMD_DIRTY, 8'h00, 10'sd0, 10'sd0);
    send_cmd(CMD_DIRTY, 8'h00, 10'sd0, 10'sd511);
    send_cmd(CMD_READ, 8'h00, 10'sd31, 10'sd5);
    send_cmd(CMD_MOVE, 8'h00, -10'sd512, -10'sd512);
    send_cmd(3'd6, 8'hFF, 10'sd511, 10'sd511);
    send_cmd(3'd7, 8'h00, -10'sd512, -10'sd512);
    send_cmd(CMD_CLEAR, 8'h00, 10'sd0, 10'sd0);
    send_cmd(CMD_DIRTY, 8'h00, 10'sd0, 10'sd4);
    send_cmd(CMD_READ, 8'h00, 10'sd31, 10'sd6);

    goal = sent + RANDOM_ITEMS;
    while (sent < goal) begin
      if (sent >= goal - CALM_ITEMS) calm = 1'b1;
      random_cmd();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("text_terminal_buffer test passed");
    else
      $display("text_terminal_buffer test failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ttb_pkg.sv
rtl/core/ttb_cell_store.sv
rtl/core/text_terminal_buffer.sv
bench/text_terminal_buffer_checker.sv
bench/text_terminal_buffer_tb.sv
